// File: rtl/core/apdg_pkg.sv
// Shared types and constants for the aligned-pair free-energy minimum block.
`timescale 1ns / 1ps

package apdg_pkg;

  // Default widths of the energy entries and of the running accumulator
  localparam int ENERGY_WIDTH_DEFAULT = 16;
  localparam int ACC_WIDTH_DEFAULT    = 24;

  // Fixed field widths of the item channel
  localparam int CHAR_WIDTH  = 8;
  localparam int ADDR_WIDTH  = 19;
  localparam int VALUE_WIDTH = 16;

  // Base codes and window geometry
  localparam int CODE_WIDTH = 3;
  localparam int WIN_DEPTH  = 4;
  localparam int FILL_WIDTH = 3;

  localparam int unsigned TABLE_DEPTH = 390625;

  typedef logic [CODE_WIDTH-1:0] code_t;

  localparam code_t GAP_CODE = 3'd4;

  // Base-5 weights of the window slots, slot 0 oldest
  localparam logic [ADDR_WIDTH-1:0] PROBE_WEIGHT [WIN_DEPTH] =
    '{19'd1, 19'd5, 19'd25, 19'd125};
  localparam logic [ADDR_WIDTH-1:0] TARGET_WEIGHT [WIN_DEPTH] =
    '{19'd625, 19'd3125, 19'd15625, 19'd78125};

  // Result queue
  localparam int OUT_DEPTH     = 4;
  localparam int OUT_PTR_WIDTH = 2;
  localparam int PEND_WIDTH    = 3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PAIR  = 1'b1
  } op_t;

  // Resolved codes of one character pair
  typedef struct packed {
    code_t probe;
    code_t target;
    logic  bad;
    logic  both_gap;
  } pair_code_t;

  // Control that travels with each pipeline slot
  typedef struct packed {
    logic rd;
    logic last;
    logic err;
  } token_t;

endpackage

// File: rtl/core/apdg_ifs.sv
// Item and result channel interfaces of the free-energy minimum block.
`timescale 1ns / 1ps

interface apdg_item_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic        [apdg_pkg::CHAR_WIDTH-1:0]  probe_char;
  logic        [apdg_pkg::CHAR_WIDTH-1:0]  target_char;
  logic                                   last_pair;
  logic        [apdg_pkg::ADDR_WIDTH-1:0]  table_address;
  logic signed [apdg_pkg::VALUE_WIDTH-1:0] table_value;

  modport source (
    output valid, operation, probe_char, target_char, last_pair,
           table_address, table_value,
    input  ready
  );

  modport sink (
    input  valid, operation, probe_char, target_char, last_pair,
           table_address, table_value,
    output ready
  );
endinterface

interface apdg_result_if #(
  parameter int ACC_WIDTH = apdg_pkg::ACC_WIDTH_DEFAULT
);
  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] min_delta_g;
  logic                        bad_char;

  modport source (
    output valid, min_delta_g, bad_char,
    input  ready
  );

  modport sink (
    input  valid, min_delta_g, bad_char,
    output ready
  );
endinterface

// File: rtl/core/apdg_resolve.sv
// Character decoder: folds case and resolves IUPAC codes of one aligned pair.
`timescale 1ns / 1ps

module apdg_resolve (
  input  logic [apdg_pkg::CHAR_WIDTH-1:0] probe_char,
  input  logic [apdg_pkg::CHAR_WIDTH-1:0] target_char,
  output apdg_pkg::pair_code_t            codes
);

  // Marks a character that is neither a plain base nor a gap
  localparam apdg_pkg::code_t NOT_PLAIN = 3'd5;

  function automatic logic [apdg_pkg::CHAR_WIDTH-1:0] fold_case(
    input logic [apdg_pkg::CHAR_WIDTH-1:0] c
  );
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic apdg_pkg::code_t plain_code(
    input logic [apdg_pkg::CHAR_WIDTH-1:0] c
  );
    apdg_pkg::code_t code;
    unique case (fold_case(c))
      "A":     code = 3'd0;
      "C":     code = 3'd1;
      "G":     code = 3'd2;
      "T":     code = 3'd3;
      "-":     code = apdg_pkg::GAP_CODE;
      default: code = NOT_PLAIN;
    endcase
    return code;
  endfunction

  // Member set of an ambiguity code, bit k allows base code k
  function automatic logic [3:0] ambig_set(
    input logic [apdg_pkg::CHAR_WIDTH-1:0] c
  );
    logic [3:0] set;
    unique case (fold_case(c))
      "M":     set = 4'h3;
      "R":     set = 4'h5;
      "S":     set = 4'h6;
      "W":     set = 4'h9;
      "Y":     set = 4'hA;
      "K":     set = 4'hC;
      "V":     set = 4'h7;
      "H":     set = 4'hB;
      "D":     set = 4'hD;
      "B":     set = 4'hE;
      "N":     set = 4'hF;
      default: set = 4'h0;
    endcase
    return set;
  endfunction

  // Returns {bad, code}: prefer the other side's base, else highest member
  function automatic logic [apdg_pkg::CODE_WIDTH:0] resolve(
    input logic [apdg_pkg::CHAR_WIDTH-1:0] c,
    input apdg_pkg::code_t                 other
  );
    apdg_pkg::code_t code;
    logic [3:0]      set;
    logic [apdg_pkg::CODE_WIDTH:0] r;
    code = plain_code(c);
    set  = ambig_set(c);
    if (code <= apdg_pkg::GAP_CODE) begin
      r = {1'b0, code};
    end else if (set == 4'h0) begin
      r = {1'b1, apdg_pkg::GAP_CODE};
    end else if (other < 3'd4 && set[other[1:0]]) begin
      r = {1'b0, other};
    end else if (set[3]) begin
      r = {1'b0, 3'd3};
    end else if (set[2]) begin
      r = {1'b0, 3'd2};
    end else begin
      r = {1'b0, 3'd1};
    end
    return r;
  endfunction

  logic [apdg_pkg::CODE_WIDTH:0] probe_res;
  logic [apdg_pkg::CODE_WIDTH:0] target_res;

  // Resolve probe against the target's plain code, then target against probe
  always_comb begin
    probe_res  = resolve(probe_char, plain_code(target_char));
    target_res = resolve(target_char, probe_res[apdg_pkg::CODE_WIDTH-1:0]);
    codes.probe    = probe_res[apdg_pkg::CODE_WIDTH-1:0];
    codes.target   = target_res[apdg_pkg::CODE_WIDTH-1:0];
    codes.bad      = probe_res[apdg_pkg::CODE_WIDTH] | target_res[apdg_pkg::CODE_WIDTH];
    codes.both_gap = (codes.probe == apdg_pkg::GAP_CODE) &&
                     (codes.target == apdg_pkg::GAP_CODE);
  end

endmodule

// File: rtl/core/aligned_pair_delta_g_min.sv
// Top level: aligned-pair nearest-neighbor free-energy running minimum.
`timescale 1ns / 1ps

// Takes one beat per cycle on the item channel while ready is high: either a
// write of one energy table word or one aligned probe/target character pair.
// The energy table is a 390625 x ENERGY_WIDTH synchronous memory with one write
// and one read port; it is not cleared at reset and every entry a sequence can
// reach must be written first. Each pair that is not a gap in both and leaves
// the windows full costs one table read, so the sustained rate is one pair per
// cycle while ready is high. A final pair that leaves the windows full holds
// ready low through ST_FLUSH1 and ST_FLUSH2 while two gap columns are flushed
// through the same read port. A sequence's minimum passes tok_r, tok_d, tok_m
// into the result queue; up to four results queue before the item channel stalls.
module aligned_pair_delta_g_min #(
  parameter int ENERGY_WIDTH = apdg_pkg::ENERGY_WIDTH_DEFAULT,
  parameter int ACC_WIDTH    = apdg_pkg::ACC_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  apdg_item_if.sink     items,
  apdg_result_if.source results
);

  localparam int SUM_WIDTH = ((ACC_WIDTH > ENERGY_WIDTH) ? ACC_WIDTH : ENERGY_WIDTH) + 1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_FLOOR = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH1,
    ST_FLUSH2
  } state_t;

  state_t state;

  // Sequence state
  apdg_pkg::code_t                     pwin [apdg_pkg::WIN_DEPTH];
  apdg_pkg::code_t                     twin [apdg_pkg::WIN_DEPTH];
  logic [apdg_pkg::FILL_WIDTH-1:0]     fill;
  logic                                cerr;

  // Front-end control
  apdg_pkg::pair_code_t                codes;
  logic                                accept;
  logic                                is_pair;
  logic                                pair_accept;
  logic                                flushing;
  logic                                push;
  logic                                full;
  logic                                full_after;
  logic                                seq_end;
  logic                                cerr_next;
  apdg_pkg::code_t                     push_probe;
  apdg_pkg::code_t                     push_target;

  // Pipeline
  apdg_pkg::token_t                    tok_r;
  apdg_pkg::token_t                    tok_d;
  apdg_pkg::token_t                    tok_m;
  logic [apdg_pkg::ADDR_WIDTH-1:0]     rd_index;
  logic signed [ENERGY_WIDTH-1:0]      energy_mem [apdg_pkg::TABLE_DEPTH];
  logic signed [ENERGY_WIDTH-1:0]      rdata;
  logic signed [SUM_WIDTH-1:0]         sum;
  logic signed [ACC_WIDTH-1:0]         clamped;
  logic signed [ACC_WIDTH-1:0]         running;
  logic signed [ACC_WIDTH-1:0]         sum_m;
  logic signed [ACC_WIDTH-1:0]         lowest;
  logic signed [ACC_WIDTH-1:0]         lowest_cand;

  // Result queue and credit count
  logic signed [ACC_WIDTH-1:0]         res_min [apdg_pkg::OUT_DEPTH];
  logic                                res_bad [apdg_pkg::OUT_DEPTH];
  logic [apdg_pkg::OUT_PTR_WIDTH-1:0]  wptr;
  logic [apdg_pkg::OUT_PTR_WIDTH-1:0]  rptr;
  logic [apdg_pkg::OUT_PTR_WIDTH:0]    res_count;
  logic [apdg_pkg::PEND_WIDTH-1:0]     pending;
  logic                                res_beat;

  apdg_resolve u_resolve (
    .probe_char  (items.probe_char),
    .target_char (items.target_char),
    .codes       (codes)
  );

  // Take a beat only outside a flush and with room for its result
  assign items.ready = (state == ST_IDLE) &&
                       (pending < apdg_pkg::PEND_WIDTH'(apdg_pkg::OUT_DEPTH));

  // Decide what enters the windows this cycle
  always_comb begin
    accept      = items.valid && items.ready;
    is_pair     = items.operation == apdg_pkg::OP_PAIR;
    pair_accept = accept && is_pair;
    flushing    = state != ST_IDLE;
    push        = flushing || (pair_accept && !codes.both_gap);
    push_probe  = flushing ? apdg_pkg::GAP_CODE : codes.probe;
    push_target = flushing ? apdg_pkg::GAP_CODE : codes.target;
    full        = fill == apdg_pkg::FILL_WIDTH'(apdg_pkg::WIN_DEPTH);
    full_after  = full ||
                  (push && fill == apdg_pkg::FILL_WIDTH'(apdg_pkg::WIN_DEPTH - 1));
    seq_end     = (pair_accept && items.last_pair && !full_after) ||
                  (state == ST_FLUSH2);
    cerr_next   = cerr || (pair_accept && codes.bad);
  end

  // Flush sequencer: two gap columns after a final pair with full windows
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pair_accept && items.last_pair && full_after) begin
            state <= ST_FLUSH1;
          end
        end
        ST_FLUSH1: state <= ST_FLUSH2;
        ST_FLUSH2: state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Track fill level and the bad-character flag; drop both at sequence end
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      cerr <= 1'b0;
    end else if (seq_end) begin
      fill <= '0;
      cerr <= 1'b0;
    end else begin
      if (push && !full) begin
        fill <= fill + 1'b1;
      end
      cerr <= cerr_next;
    end
  end

  // Advance the windows: fill slot by slot, then shift toward slot 0
  always_ff @(posedge clk) begin
    if (push) begin
      if (full) begin
        for (int k = 0; k < apdg_pkg::WIN_DEPTH - 1; k++) begin
          pwin[k] <= pwin[k+1];
          twin[k] <= twin[k+1];
        end
        pwin[apdg_pkg::WIN_DEPTH-1] <= push_probe;
        twin[apdg_pkg::WIN_DEPTH-1] <= push_target;
      end else begin
        pwin[fill[1:0]] <= push_probe;
        twin[fill[1:0]] <= push_target;
      end
    end
  end

  // Issue a read slot for every push that leaves the windows full
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_r <= '0;
      tok_d <= '0;
      tok_m <= '0;
    end else begin
      tok_r.rd   <= push && full_after;
      tok_r.last <= seq_end;
      tok_r.err  <= cerr_next;
      tok_d      <= tok_r;
      tok_m      <= tok_d;
    end
  end

  // Base-5 table index of the current windows
  always_comb begin
    rd_index = '0;
    for (int k = 0; k < apdg_pkg::WIN_DEPTH; k++) begin
      rd_index = rd_index
               + apdg_pkg::ADDR_WIDTH'(pwin[k]) * apdg_pkg::PROBE_WEIGHT[k]
               + apdg_pkg::ADDR_WIDTH'(twin[k]) * apdg_pkg::TARGET_WEIGHT[k];
    end
  end

  // Energy table: write on an in-range table beat, read the window entry every cycle
  always_ff @(posedge clk) begin
    if (accept && !is_pair &&
        items.table_address < apdg_pkg::ADDR_WIDTH'(apdg_pkg::TABLE_DEPTH)) begin
      energy_mem[items.table_address] <= ENERGY_WIDTH'(items.table_value);
    end
    rdata <= energy_mem[rd_index];
  end

  // Add the entry, clamp at zero above and saturate below
  always_comb begin
    sum = SUM_WIDTH'(running) + SUM_WIDTH'(rdata);
    if (sum > 0) begin
      clamped = '0;
    end else if (sum < SUM_WIDTH'(ACC_FLOOR)) begin
      clamped = ACC_FLOOR;
    end else begin
      clamped = ACC_WIDTH'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
    end else if (tok_d.last) begin
      running <= '0;
    end else if (tok_d.rd) begin
      running <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    sum_m <= clamped;
  end

  // Fold the newest sum into the minimum; emit and restart at sequence end
  assign lowest_cand = (tok_m.rd && sum_m < lowest) ? sum_m : lowest;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest <= '0;
    end else if (tok_m.last) begin
      lowest <= '0;
    end else begin
      lowest <= lowest_cand;
    end
  end

  // Result queue
  assign res_beat            = results.valid && results.ready;
  assign results.valid       = res_count != '0;
  assign results.min_delta_g = res_min[rptr];
  assign results.bad_char    = res_bad[rptr];

  always_ff @(posedge clk) begin
    if (tok_m.last) begin
      res_min[wptr] <= lowest_cand;
      res_bad[wptr] <= tok_m.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      res_count <= '0;
    end else begin
      if (tok_m.last) begin
        wptr <= wptr + 1'b1;
      end
      if (res_beat) begin
        rptr <= rptr + 1'b1;
      end
      if (tok_m.last && !res_beat) begin
        res_count <= res_count + 1'b1;
      end else if (!tok_m.last && res_beat) begin
        res_count <= res_count - 1'b1;
      end
    end
  end

  // Credits: one per final pair in flight or queued
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      if (pair_accept && items.last_pair && !res_beat) begin
        pending <= pending + 1'b1;
      end else if (!(pair_accept && items.last_pair) && res_beat) begin
        pending <= pending - 1'b1;
      end
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= apdg_pkg::PEND_WIDTH'(apdg_pkg::OUT_DEPTH))
    else $error("result credits exceed queue depth");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    tok_m.last |-> res_count < (apdg_pkg::OUT_PTR_WIDTH + 1)'(apdg_pkg::OUT_DEPTH))
    else $error("result written into a full queue");

  a_flush_full: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> full && !items.ready)
    else $error("flush step without full windows or with ready high");

  a_running_nonpos: assert property (@(posedge clk) disable iff (rst)
    !running[ACC_WIDTH-1] |-> running == '0)
    else $error("running energy above zero");

  a_result_follows_credit: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> pending != '0)
    else $error("result shown without a matching credit");

endmodule
